/* rtl/indexed_list_stack_defines.svh */
// assertion macros for the list stack
`ifndef INDEXED_LIST_STACK_DEFINES_SVH
`define INDEXED_LIST_STACK_DEFINES_SVH

// same-cycle implication, sampled on the block clock
`define ILS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the block clock
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ils_pkg.sv */
`default_nettype none

package ils_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W = 3;
  localparam int unsigned ST_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP    = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         position;
  } ils_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [ST_W-1:0]          status;
    logic [CNT_W-1:0]         count;
  } ils_out_t;

  // control broadcast along the row of cells
  typedef struct packed {
    logic             wr;
    logic [IDX_W-1:0] wr_pos;
    logic [IDX_W-1:0] rd_pos;
  } ils_cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/ils_cell.sv */
`default_nettype none

module ils_cell
  import ils_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic [IDX_W-1:0]      idx_i,
  input  wire ils_cell_ctrl_t        ctrl_i,
  input  wire logic [DATA_W-1:0]     new_word_i,
  input  wire logic [DATA_W-1:0]     left_word_i,
  output      logic [DATA_W-1:0]     word_o,
  output      logic [DATA_W-1:0]     rd_word_o
);

  logic [DATA_W-1:0] word_q;
  logic [DATA_W-1:0] word_d;

  // cells above the write slot take their lower neighbor
  always_comb begin
    word_d = word_q;
    if (ctrl_i.wr && (idx_i == ctrl_i.wr_pos)) begin
      word_d = new_word_i;
    end else if (ctrl_i.wr && (idx_i > ctrl_i.wr_pos)) begin
      word_d = left_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o    = word_q;
  assign rd_word_o = (idx_i == ctrl_i.rd_pos) ? word_q : '0;

endmodule

`default_nettype wire

/* rtl/indexed_list_stack.sv */
// indexed list stack: a row of word cells, each shifting up into its neighbor on insert
// the result of an accepted word is registered and shows in the output register in the next cycle
// throughput: one operation per cycle while the output side takes results
// reset: count and output valid clear at once; cell contents are undefined until written
// only entries below the count are ever read, so no clearing pass is needed
`default_nettype none

`include "indexed_list_stack_defines.svh"

module indexed_list_stack
  import ils_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_stall_o,
  input  wire ils_in_t  in_word_i,
  output      logic     out_valid_o,
  input  wire logic     out_stall_i,
  output      ils_out_t out_word_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q;
  ils_out_t         out_q, out_d;
  logic             accept;

  // operation decode
  logic is_write, is_insert, is_pop, is_peek, is_read, is_clear;
  logic full, empty, in_range;
  logic [IDX_W-1:0] wr_pos, rd_pos;
  ils_cell_ctrl_t ctrl;

  // cell row wiring
  logic [DATA_W-1:0] cell_word [DEPTH];
  logic [DATA_W-1:0] cell_rd   [DEPTH];
  logic [DATA_W-1:0] rd_word;

  // the result register frees itself when the consumer takes its word,
  // so a new operation can enter in that same cycle
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_insert = (in_word_i.operation == OP_INSERT);
  assign is_write  = (in_word_i.operation == OP_APPEND) || is_insert;
  assign is_pop    = (in_word_i.operation == OP_POP);
  assign is_peek   = (in_word_i.operation == OP_PEEK);
  assign is_read   = (in_word_i.operation == OP_READ);
  assign is_clear  = (in_word_i.operation == OP_CLEAR);

  assign full     = (cnt_q == CNT_W'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign in_range = (in_word_i.position < cnt_q);

  // insert within the list lands at the position, anything else goes to the top
  always_comb begin
    if (is_insert && !empty && (in_word_i.position <= cnt_q)) begin
      wr_pos = in_word_i.position[IDX_W-1:0];
    end else begin
      wr_pos = cnt_q[IDX_W-1:0];
    end
  end

  // one read port: indexed read or top of stack
  always_comb begin
    if (is_read) begin
      rd_pos = in_word_i.position[IDX_W-1:0];
    end else begin
      rd_pos = IDX_W'(cnt_q - CNT_W'(1));
    end
  end

  assign ctrl.wr     = accept && is_write && !full;
  assign ctrl.wr_pos = wr_pos;
  assign ctrl.rd_pos = rd_pos;

  // row of cells; cell 0 has no lower neighbor
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] left_word;
    if (k == 0) begin : g_first
      assign left_word = in_word_i.value;
    end else begin : g_rest
      assign left_word = cell_word[k-1];
    end
    ils_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(k)),
      .ctrl_i      (ctrl),
      .new_word_i  (in_word_i.value),
      .left_word_i (left_word),
      .word_o      (cell_word[k]),
      .rd_word_o   (cell_rd[k])
    );
  end

  // only the addressed cell drives a nonzero word
  always_comb begin
    rd_word = '0;
    for (int unsigned k = 0; k < DEPTH; k++) begin
      rd_word = rd_word | cell_rd[k];
    end
  end

  // count and result
  always_comb begin
    cnt_d         = cnt_q;
    out_d.data    = '0;
    out_d.status  = ST_OK;
    if (is_write) begin
      if (full) begin
        out_d.status = ST_FULL;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end else if (is_pop || is_peek) begin
      if (empty) begin
        out_d.status = ST_EMPTY;
      end else begin
        out_d.data = rd_word;
        if (is_pop) begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
    end else if (is_read) begin
      if (in_range) begin
        out_d.data = rd_word;
      end else begin
        out_d.status = ST_RANGE;
      end
    end else if (is_clear) begin
      cnt_d = '0;
    end
    out_d.count = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload register, loaded only on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `ILS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "count exceeds depth")
  `ILS_ASSERT_NEXT(a_clear_empties, accept && is_clear, cnt_q == '0, "clear left entries")
  `ILS_ASSERT_NEXT(a_write_grows, ctrl.wr, cnt_q == $past(cnt_q) + CNT_W'(1),
                   "write did not grow count")
  `ILS_ASSERT_NOW(a_err_zero_data, out_valid_q && (out_q.status != ST_OK),
                  out_q.data == '0, "error result carries data")
  `ILS_ASSERT_NOW(a_count_matches, out_valid_q && !accept, out_q.count == cnt_q,
                  "result count differs from held count")

endmodule

`default_nettype wire
